>>> hdl/ptg_pkg.sv
// Shared widths and constants for the prime test with gap statistics block.
package ptg_pkg;

  // Width of the candidate and of every statistics field.
  localparam int unsigned VALUE_BITS = 16;

  // Trial divisor width: it must reach the first divisor whose square exceeds the candidate.
  localparam int unsigned DIV_BITS = (VALUE_BITS + 1) / 2 + 1;

  // Partial remainder width: one bit over the divisor, to hold the value after a shift.
  localparam int unsigned REM_BITS = DIV_BITS + 1;

  // Width of the running square of the divisor.
  localparam int unsigned SQ_BITS = VALUE_BITS + 2;

  // Width of the bit counter that walks the candidate once per divisor.
  localparam int unsigned CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  // First trial divisor and its square.
  localparam logic [DIV_BITS-1:0] FIRST_DIV = DIV_BITS'(2);
  localparam logic [SQ_BITS-1:0]  FIRST_SQ  = SQ_BITS'(4);

  // Smallest prime.
  localparam logic [VALUE_BITS-1:0] MIN_PRIME = VALUE_BITS'(2);

  // Largest value a statistics field can hold.
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

endpackage

>>> hdl/ptg_in_if.sv
// Input channel: one candidate number per word.
interface ptg_in_if;
  import ptg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

>>> hdl/ptg_out_if.sv
// Output channel: verdict and running prime statistics, one word per candidate.
interface ptg_out_if;
  import ptg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  is_prime;
  logic [VALUE_BITS-1:0] primes_found;
  logic [VALUE_BITS-1:0] latest_prime;
  logic [VALUE_BITS-1:0] total_gap;
  logic [VALUE_BITS-1:0] largest_gap;

  modport source (output valid, output is_prime, output primes_found, output latest_prime,
                  output total_gap, output largest_gap, input ready);
  modport sink   (input valid, input is_prime, input primes_found, input latest_prime,
                  input total_gap, input largest_gap, output ready);
endinterface

>>> hdl/prime_test_with_gap_stats_unit.sv
// Top level: trial-division primality test with running prime gap statistics.
//
// Usage
//   in_i takes one candidate word; out_o returns one word per candidate with the
//   verdict and the statistics over all primes seen since reset (count, latest
//   prime, sum of gaps and largest gap). Both channels use a valid/ready handshake.
//   One candidate is in work at a time: in_i.ready is high only while the unit idles.
// Sequence
//   Each trial divisor d (from 2 while d*d <= candidate) takes a check step, then the
//   candidate shifted through a bit-serial restoring remainder unit one bit a cycle,
//   then a step state. A candidate below 2 goes straight to the output stage; a
//   composite goes there on the first zero remainder, and a prime passes the gap
//   and update states first. The unit returns to idle from the output stage before
//   it takes the next word.
// Reset
//   rst_ni clears all statistics and leaves the unit idle with no word on out_o.
// Stalls
//   A finished word waits in the output register while out_o.ready is low; the unit
//   already takes the next candidate and holds that candidate's result until the
//   output register is free.
module prime_test_with_gap_stats_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptg_in_if.sink      in_i,
  ptg_out_if.source   out_o
);
  import ptg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_STEP,
    ST_GAP,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  state_e                state_q;
  logic [VALUE_BITS-1:0] cand_q;
  logic [VALUE_BITS-1:0] shift_q;
  logic [REM_BITS-1:0]   rem_q;
  logic [DIV_BITS-1:0]   div_q;
  logic [SQ_BITS-1:0]    sq_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  prime_q;
  logic                  gap_en_q;
  logic [VALUE_BITS-1:0] gap_q;

  // Statistics.
  logic                  have_prime_q;
  logic [VALUE_BITS-1:0] last_prime_q;
  logic [VALUE_BITS-1:0] prime_count_q;
  logic [VALUE_BITS-1:0] gap_sum_q;
  logic [VALUE_BITS-1:0] gap_max_q;

  // Output register.
  logic                  out_valid_q;
  logic                  out_prime_q;
  logic [VALUE_BITS-1:0] out_count_q;
  logic [VALUE_BITS-1:0] out_latest_q;
  logic [VALUE_BITS-1:0] out_sum_q;
  logic [VALUE_BITS-1:0] out_max_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;
  logic [REM_BITS-1:0]   rem_shift;
  logic [REM_BITS-1:0]   rem_d;
  logic [SQ_BITS-1:0]    sq_d;
  logic                  sq_over;
  logic [VALUE_BITS:0]   sum_wide;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == ST_EMIT) && out_free;

  // One restoring remainder step: bring in the next candidate bit, subtract if it fits.
  always_comb begin
    rem_shift = {rem_q[REM_BITS-2:0], shift_q[VALUE_BITS-1]};
    if (rem_shift >= REM_BITS'(div_q)) begin
      rem_d = rem_shift - REM_BITS'(div_q);
    end else begin
      rem_d = rem_shift;
    end
  end

  // Square of the next divisor: (d + 1)^2 = d^2 + 2d + 1.
  assign sq_d    = sq_q + SQ_BITS'({div_q, 1'b1});
  assign sq_over = sq_q > SQ_BITS'(cand_q);

  // Saturating gap sum.
  assign sum_wide = {1'b0, gap_sum_q} + {1'b0, gap_q};

  // Sequencer, statistics and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cand_q        <= '0;
      shift_q       <= '0;
      rem_q         <= '0;
      div_q         <= '0;
      sq_q          <= '0;
      cnt_q         <= '0;
      prime_q       <= 1'b0;
      gap_en_q      <= 1'b0;
      gap_q         <= '0;
      have_prime_q  <= 1'b0;
      last_prime_q  <= '0;
      prime_count_q <= '0;
      gap_sum_q     <= '0;
      gap_max_q     <= '0;
      out_valid_q   <= 1'b0;
      out_prime_q   <= 1'b0;
      out_count_q   <= '0;
      out_latest_q  <= '0;
      out_sum_q     <= '0;
      out_max_q     <= '0;
    end else begin
      // The receiver takes the pending word and no new word replaces it.
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cand_q  <= in_i.candidate;
            div_q   <= FIRST_DIV;
            sq_q    <= FIRST_SQ;
            prime_q <= 1'b0;
            if (in_i.candidate < MIN_PRIME) begin
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_CHECK;
            end
          end
        end

        // Stop once the divisor squared passes the candidate; otherwise start a division.
        ST_CHECK: begin
          if (sq_over) begin
            prime_q <= 1'b1;
            state_q <= ST_GAP;
          end else begin
            shift_q <= cand_q;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIVIDE;
          end
        end

        // One candidate bit per cycle through the remainder unit.
        ST_DIVIDE: begin
          rem_q   <= rem_d;
          shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
          cnt_q   <= cnt_q + CNT_BITS'(1);
          if (cnt_q == CNT_BITS'(VALUE_BITS - 1)) begin
            state_q <= ST_STEP;
          end
        end

        // A zero remainder means a factor was found.
        ST_STEP: begin
          if (rem_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            div_q   <= div_q + DIV_BITS'(1);
            sq_q    <= sq_d;
            state_q <= ST_CHECK;
          end
        end

        // Gap to the previous prime, only when this prime lies above it.
        ST_GAP: begin
          gap_q    <= cand_q - last_prime_q;
          gap_en_q <= have_prime_q && (cand_q > last_prime_q);
          state_q  <= ST_UPDATE;
        end

        ST_UPDATE: begin
          if (gap_en_q) begin
            gap_sum_q <= sum_wide[VALUE_BITS] ? VALUE_MAX : sum_wide[VALUE_BITS-1:0];
            if (gap_q > gap_max_q) begin
              gap_max_q <= gap_q;
            end
          end
          last_prime_q <= cand_q;
          have_prime_q <= 1'b1;
          if (prime_count_q != VALUE_MAX) begin
            prime_count_q <= prime_count_q + VALUE_BITS'(1);
          end
          state_q <= ST_EMIT;
        end

        // Load the output register once it is free.
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_prime_q  <= prime_q;
            out_count_q  <= prime_count_q;
            out_latest_q <= last_prime_q;
            out_sum_q    <= gap_sum_q;
            out_max_q    <= gap_max_q;
            state_q      <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.is_prime     = out_prime_q;
  assign out_o.primes_found = out_count_q;
  assign out_o.latest_prime = out_latest_q;
  assign out_o.total_gap    = out_sum_q;
  assign out_o.largest_gap  = out_max_q;

endmodule

>>> hdl/ptg_checker.sv
// Port checker for the prime test unit, with its bind to the top level.
module ptg_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          is_prime_i,
  input  logic [ptg_pkg::VALUE_BITS-1:0] primes_found_i,
  input  logic [ptg_pkg::VALUE_BITS-1:0] latest_prime_i,
  input  logic [ptg_pkg::VALUE_BITS-1:0] total_gap_i,
  input  logic [ptg_pkg::VALUE_BITS-1:0] largest_gap_i
);
  import ptg_pkg::*;

  // A stalled result word holds: valid, verdict, count and latest prime stay stable.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(primes_found_i)
      && $stable(latest_prime_i) && $stable(is_prime_i))
    else $error("stalled result word changed");

  // Only one candidate is in work: after a word is taken the input closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input stayed open after taking a candidate");

  // A prime verdict always comes with a counted, odd or two-valued latest prime.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_prime_i |-> primes_found_i != '0
      && (latest_prime_i[0] || latest_prime_i == MIN_PRIME))
    else $error("prime verdict with inconsistent statistics");

  // The largest gap never exceeds the gap sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> largest_gap_i <= total_gap_i)
    else $error("largest gap above total gap");

endmodule

bind prime_test_with_gap_stats_unit ptg_checker u_ptg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .is_prime_i     (out_o.is_prime),
  .primes_found_i (out_o.primes_found),
  .latest_prime_i (out_o.latest_prime),
  .total_gap_i    (out_o.total_gap),
  .largest_gap_i  (out_o.largest_gap)
);

>>> tb/sv/prime_test_with_gap_stats_unit_test.sv
`timescale 1ns / 1ps
// Testbench for the prime test unit: checks verdicts and running prime gap statistics.
module prime_test_with_gap_stats_unit_test;
  import ptg_pkg::*;

  localparam int unsigned CLK_HALF_NS   = 5;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned HOLD_CYCLES   = 12_000;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned PHASE_ITEMS   = 20;
  localparam int unsigned REPORT_LIMIT  = 100;
  localparam int unsigned LIMIT_CYCLES  = 6_000_000;
  localparam int unsigned SEND_IDLE_PCT = 71;
  localparam int unsigned RECV_IDLE_PCT = 71;
  localparam int unsigned BOTH_IDLE_PCT = 10;

  typedef logic [VALUE_BITS-1:0] value_t;

  // One predicted output word, tagged with the candidate that caused it.
  typedef struct packed {
    value_t candidate;
    logic   is_prime;
    value_t primes_found;
    value_t latest_prime;
    value_t total_gap;
    value_t largest_gap;
  } verdict_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} traffic_e;

  // Small numbers, bit extremes, the largest primes, out-of-order and repeated primes.
  // The jump from 5 to 65521 and back down to 2 and up again saturates the gap sum.
  localparam int unsigned CORNER_COUNT = 21;
  localparam value_t CORNER_CANDIDATES [CORNER_COUNT] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd65535, 16'd65534,
    16'd65521, 16'd65521, 16'd2, 16'd65521, 16'd65519, 16'd32749, 16'd32768, 16'd257,
    16'd256, 16'hAAAA, 16'h5555
  };

  logic clk_i;
  logic rst_ni;

  ptg_in_if  cand_if ();
  ptg_out_if stats_if ();

  prime_test_with_gap_stats_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cand_if),
    .out_o  (stats_if)
  );

  // Predictor state, mirroring the statistics registers of the unit.
  value_t prev_prime  = '0;
  bit     seen_prime  = 1'b0;
  value_t prime_tally = '0;
  value_t gap_total   = '0;
  value_t gap_peak    = '0;

  value_t      pending_candidates[$];
  verdict_t    expected_verdicts[$];
  traffic_e    traffic_mode  = IDLE_NONE;
  bit          hold_wanted   = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned hold_left     = 0;
  bit          cand_taken    = 1'b0;
  int unsigned words_queued  = 0;
  int unsigned words_checked = 0;
  int unsigned mismatch_count = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  function automatic bit trial_is_prime(value_t n);
    int unsigned d;
    if (n < MIN_PRIME) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Updates the predicted statistics with one candidate and returns the word it yields.
  function automatic verdict_t predict_verdict(value_t n);
    verdict_t            w;
    value_t              gap;
    logic [VALUE_BITS:0] sum;
    w.candidate = n;
    w.is_prime  = trial_is_prime(n);
    if (w.is_prime) begin
      // A gap counts only when the new prime lies above the previous one.
      if (seen_prime && n > prev_prime) begin
        gap       = n - prev_prime;
        sum       = {1'b0, gap_total} + {1'b0, gap};
        gap_total = sum[VALUE_BITS] ? VALUE_MAX : sum[VALUE_BITS-1:0];
        if (gap > gap_peak) gap_peak = gap;
      end
      prev_prime = n;
      seen_prime = 1'b1;
      if (prime_tally != VALUE_MAX) prime_tally = prime_tally + 1'b1;
    end
    w.primes_found = prime_tally;
    w.latest_prime = prev_prime;
    w.total_gap    = gap_total;
    w.largest_gap  = gap_peak;
    return w;
  endfunction

  function automatic bit roll_pct(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit sender_pauses();
    case (traffic_mode)
      IDLE_SEND: return roll_pct(SEND_IDLE_PCT);
      IDLE_BOTH: return roll_pct(BOTH_IDLE_PCT);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (traffic_mode)
      IDLE_RECV: return roll_pct(RECV_IDLE_PCT);
      IDLE_BOTH: return roll_pct(BOTH_IDLE_PCT);
      default:   return 1'b0;
    endcase
  endfunction

  task automatic note_mismatch(string what, value_t cand, value_t want, value_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: candidate %0d: %s expected %0d, actual %0d", $time, cand, what, want,
               got);
    end
  endtask

  // Driver: presents the next candidate word once the current one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!cand_if.valid || cand_taken) begin
        if (pending_candidates.size() != 0 && !sender_pauses()) begin
          cand_if.valid     <= 1'b1;
          cand_if.candidate <= pending_candidates.pop_front();
        end else begin
          cand_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the unit up.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      stats_if.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (hold_wanted && !hold_done) begin
      stats_if.ready <= 1'b0;
      hold_left      <= HOLD_CYCLES;
      hold_done      <= 1'b1;
    end else begin
      stats_if.ready <= !receiver_stalls();
    end
  end

  // Monitor: predicts on each accepted candidate and checks each returned word.
  always @(posedge clk_i) begin : monitor
    verdict_t want;
    cand_taken = 1'b0;
    if (rst_ni) begin
      if (cand_if.valid && cand_if.ready) begin
        cand_taken = 1'b1;
        expected_verdicts.push_back(predict_verdict(cand_if.candidate));
      end
      if (stats_if.valid && stats_if.ready) begin
        words_checked++;
        if (expected_verdicts.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word, expected none, actual prime %0b count %0d",
                   $time, stats_if.is_prime, stats_if.primes_found);
        end else begin
          want = expected_verdicts.pop_front();
          if (stats_if.is_prime !== want.is_prime)
            note_mismatch("is_prime", want.candidate, value_t'(want.is_prime),
                          value_t'(stats_if.is_prime));
          if (stats_if.primes_found !== want.primes_found)
            note_mismatch("primes_found", want.candidate, want.primes_found,
                          stats_if.primes_found);
          if (stats_if.latest_prime !== want.latest_prime)
            note_mismatch("latest_prime", want.candidate, want.latest_prime,
                          stats_if.latest_prime);
          if (stats_if.total_gap !== want.total_gap)
            note_mismatch("total_gap", want.candidate, want.total_gap, stats_if.total_gap);
          if (stats_if.largest_gap !== want.largest_gap)
            note_mismatch("largest_gap", want.candidate, want.largest_gap,
                          stats_if.largest_gap);
        end
      end
    end
  end

  task automatic queue_candidate(value_t n);
    pending_candidates.push_back(n);
    words_queued++;
  endtask

  // Mostly rising runs of candidates, with restarts, a few runs near the top and noise.
  task automatic queue_random_run(int unsigned count);
    int unsigned cursor;
    int unsigned r;
    int unsigned i;
    cursor = $urandom_range(100);
    for (i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 15) begin
        queue_candidate(value_t'($urandom_range(16'hFFFF)));
      end else begin
        if (r < 18) cursor = $urandom_range(65500, 60000);
        else if (r < 25) cursor = $urandom_range(4095);
        else cursor = cursor + $urandom_range(24, 1);
        queue_candidate(value_t'(cursor));
      end
    end
  endtask

  task automatic wait_drained();
    while (words_checked != words_queued) @(negedge clk_i);
  endtask

  task automatic run_phase(traffic_e mode, int unsigned count);
    @(posedge clk_i);
    traffic_mode = mode;
    queue_random_run(count);
    wait_drained();
  endtask

  // Stimulus and end of test.
  initial begin : stimulus
    int unsigned i;
    rst_ni             = 1'b0;
    cand_if.valid      = 1'b0;
    cand_if.candidate  = '0;
    stats_if.ready     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed corner cases without idling.
    @(posedge clk_i);
    for (i = 0; i < CORNER_COUNT; i++) queue_candidate(CORNER_CANDIDATES[i]);
    wait_drained();

    run_phase(IDLE_SEND, PHASE_ITEMS);

    // The long receiver hold-off falls at the start of this phase.
    @(posedge clk_i);
    hold_wanted = 1'b1;
    run_phase(IDLE_RECV, PHASE_ITEMS);
    run_phase(IDLE_BOTH, PHASE_ITEMS);
    run_phase(IDLE_NONE, PHASE_ITEMS);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(2 * CLK_HALF_NS * LIMIT_CYCLES);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
